// ===== rtl/adcrf_pkg.sv =====
// Package with the shared types and constants of the ADC result register file.
package adcrf_pkg;

  // Operation carried by one command.
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_CONT  = 2'd2,
    MODE_POST  = 2'd3
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_BASE_ADDRESS   = 2'd0,
    CFG_DEFAULT_ENABLE = 2'd1,
    CFG_DEFAULT_COUNT  = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_e;

  // Source of the read data for a command in flight.
  typedef enum logic [1:0] {
    RSEL_ZERO   = 2'd0,
    RSEL_SHADOW = 2'd1,
    RSEL_STATUS = 2'd2,
    RSEL_RESULT = 2'd3
  } rsel_e;

  localparam int unsigned CNT_W   = 14;
  localparam int unsigned TAG_W   = 4;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned KERN_W  = 2;
  localparam int unsigned DATA_W  = 32;

  // Byte offsets inside one kernel.
  localparam int unsigned OFF_CONTROL = 32'h030;
  localparam int unsigned OFF_STATUS  = 32'h038;
  localparam int unsigned OFF_RESULT  = 32'h180;
  localparam int unsigned OFF_DEBUG   = 32'h1C0;

  // Word distance from the status word back to the control word.
  localparam int unsigned STATUS_TO_CONTROL = (OFF_STATUS - OFF_CONTROL) / 4;

  localparam logic [DATA_W-1:0] STATUS_BITS   = 32'h0000_0300;
  localparam logic [DATA_W-1:0] CONTROL_RESET = 32'h0000_00FF;

endpackage

// ===== rtl/adc_result_register_file.sv =====
// Top level of the ADC result register file: bus decode, result state and read pipeline.
//
// Usage
//   Commands enter on start with the payload ports; a command is taken at a clock
//   edge where start is high and busy is low. Mode selects a bus read, a bus write,
//   setting the continuous input of a result register, or posting a one-shot result.
//   Every command produces exactly one result: read_data_o with result_valid_o high
//   for one cycle, once the command has passed the first stage register and the
//   output register. Only bus reads give nonzero data.
//   Throughput is one command per cycle while busy is low. The first stage register
//   runs in step with the registered read of the shadow memory.
//   The configuration port (cfg_we_i, cfg_index_i, cfg_wdata_i) writes the base
//   address, the default enable and the default count; the user must use it only
//   while no command is in flight, as the block itself does not enforce this.
//   After reset the shadow memory is cleared by a pass that writes one word per
//   cycle over all KERNELS * KERNEL_WORDS words (512 by default), setting each
//   control word to 0xFF. busy stays high during that pass and no command is
//   taken. The receiver of results cannot stall, so the block never waits on it.
module adc_result_register_file #(
  parameter int unsigned KERNELS      = 2,
  parameter int unsigned CHANNELS     = 16,
  parameter int unsigned KERNEL_WORDS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // Command channel.
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [31:0] address_i,
  input  logic [31:0] write_data_i,
  input  logic [1:0]  kernel_i,
  input  logic [3:0]  channel_i,
  input  logic [13:0] count_value_i,
  input  logic        count_present_i,
  input  logic [3:0]  channel_tag_i,
  input  logic        tag_present_i,
  // Result channel.
  output logic        result_valid_o,
  output logic [31:0] read_data_o
);

  localparam int unsigned DEPTH       = KERNELS * KERNEL_WORDS;
  localparam int unsigned AW          = $clog2(DEPTH);
  localparam int unsigned OW          = $clog2(KERNEL_WORDS);
  localparam int unsigned KB          = KERNEL_WORDS * 4;
  localparam int unsigned TOTAL_BYTES = DEPTH * 4;
  localparam int unsigned RW          = $clog2(TOTAL_BYTES);
  localparam int unsigned OBW         = $clog2(KB);
  localparam int unsigned NE          = KERNELS * CHANNELS;
  localparam int unsigned EW          = (NE > 1) ? $clog2(NE) : 1;

  typedef struct packed {
    logic                 valid;
    adcrf_pkg::rsel_e     sel;
    logic [31:0]          word;
  } stage_t;

  // Configuration registers.
  logic [31:0]                   base_q;
  logic                          def_en_q;
  logic [adcrf_pkg::CNT_W-1:0]   def_cnt_q;

  // Per-entry result state.
  logic [adcrf_pkg::CNT_W-1:0]   conv_q [NE];
  logic                          flag_q [NE];
  logic                          cont_q [NE];
  logic [adcrf_pkg::CNT_W-1:0]   cont_cnt_q [NE];
  logic [adcrf_pkg::TAG_W-1:0]   tag_q [NE];

  // Clearing pass.
  logic                          clr_active_q;
  logic [AW-1:0]                 clr_cnt_q;
  logic [OW-1:0]                 clr_word_q;

  // Pipeline registers.
  stage_t                        s1_q, s1_d;
  logic                          out_valid_q;
  logic [31:0]                   out_data_q, out_data_d;

  // Decode signals.
  logic                          accept;
  adcrf_pkg::mode_e              mode;
  logic [31:0]                   rel;
  logic                          mapped;
  logic [RW-1:0]                 rel_lo;
  logic [adcrf_pkg::KERN_W-1:0]  k_sel;
  logic [OBW-1:0]                off;
  logic                          is_result;
  logic                          is_debug;
  logic                          is_status;
  logic [adcrf_pkg::KERN_W-1:0]  e_kern;
  logic [adcrf_pkg::CHAN_W-1:0]  e_chan;
  logic [EW-1:0]                 eidx;
  logic                          hit_entry;
  logic [31:0]                   res_word;
  logic [AW-1:0]                 word_addr;

  // RAM port signals.
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [31:0]                   ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [31:0]                   ram_rdata;

  assign busy   = clr_active_q;
  assign accept = start && !clr_active_q;
  assign mode   = adcrf_pkg::mode_e'(mode_i);

  // Address decode: relative address, kernel and byte offset.
  always_comb begin
    rel    = address_i - base_q;
    mapped = (rel < 32'(TOTAL_BYTES));
    rel_lo = rel[RW-1:0];
    k_sel  = '0;
    off    = OBW'(rel_lo);
    for (int j = 1; j < KERNELS; j++) begin
      if (rel_lo >= RW'(j * KB)) begin
        k_sel = adcrf_pkg::KERN_W'(j);
        off   = OBW'(rel_lo - RW'(j * KB));
      end
    end
    is_result = (32'(off) >= adcrf_pkg::OFF_RESULT)
             && (32'(off) < adcrf_pkg::OFF_RESULT + CHANNELS * 4);
    is_debug  = (32'(off) >= adcrf_pkg::OFF_DEBUG)
             && (32'(off) < adcrf_pkg::OFF_DEBUG + CHANNELS * 4);
    // The status word is matched on the word offset; the byte lane bits are ignored.
    is_status = (off[OBW-1:2] == (OBW-2)'(adcrf_pkg::OFF_STATUS / 4));
    word_addr = rel_lo[RW-1:2];
  end

  // Entry selection: bus offset for reads and writes, kernel and channel ports otherwise.
  always_comb begin
    if (mode == adcrf_pkg::MODE_READ || mode == adcrf_pkg::MODE_WRITE) begin
      e_kern = k_sel;
      e_chan = off[5:2];
    end else begin
      e_kern = kernel_i;
      e_chan = channel_i;
    end
    eidx      = EW'(32'(e_kern) * CHANNELS + 32'(e_chan));
    hit_entry = (32'(kernel_i) < KERNELS) && (32'(channel_i) < CHANNELS);
  end

  // Result word of the selected entry.
  always_comb begin
    res_word = '0;
    res_word[27:24] = tag_q[eidx];
    if (cont_q[eidx]) begin
      res_word[31]   = 1'b1;
      res_word[13:0] = cont_cnt_q[eidx];
    end else if (!flag_q[eidx] && def_en_q) begin
      res_word[31]   = 1'b1;
      res_word[13:0] = def_cnt_q;
    end else begin
      res_word[31]   = flag_q[eidx];
      res_word[13:0] = conv_q[eidx];
    end
  end

  // First stage contents for the command being taken.
  always_comb begin
    s1_d       = '0;
    s1_d.valid = accept;
    s1_d.sel   = adcrf_pkg::RSEL_ZERO;
    s1_d.word  = res_word;
    if (mode == adcrf_pkg::MODE_READ && mapped) begin
      if (is_result || is_debug) begin
        s1_d.sel = adcrf_pkg::RSEL_RESULT;
      end else if (is_status) begin
        s1_d.sel = adcrf_pkg::RSEL_STATUS;
      end else begin
        s1_d.sel = adcrf_pkg::RSEL_SHADOW;
      end
    end
  end

  // Shadow memory ports; the clearing pass owns the write port after reset.
  always_comb begin
    if (clr_active_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = (32'(clr_word_q) == adcrf_pkg::OFF_CONTROL / 4)
                ? adcrf_pkg::CONTROL_RESET : '0;
    end else begin
      ram_we    = accept && (mode == adcrf_pkg::MODE_WRITE) && mapped;
      ram_waddr = word_addr;
      ram_wdata = write_data_i;
    end
    ram_raddr = is_status ? word_addr - AW'(adcrf_pkg::STATUS_TO_CONTROL) : word_addr;
  end

  adcrf_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_shadow (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output selection for the command in the first stage.
  always_comb begin
    case (s1_q.sel)
      adcrf_pkg::RSEL_SHADOW: out_data_d = ram_rdata;
      adcrf_pkg::RSEL_STATUS: out_data_d = ram_rdata & adcrf_pkg::STATUS_BITS;
      adcrf_pkg::RSEL_RESULT: out_data_d = s1_q.word;
      default:                out_data_d = '0;
    endcase
    if (!s1_q.valid) begin
      out_data_d = '0;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      def_en_q  <= 1'b0;
      def_cnt_q <= '0;
    end else if (cfg_we_i) begin
      case (adcrf_pkg::cfg_idx_e'(cfg_index_i))
        adcrf_pkg::CFG_BASE_ADDRESS:   base_q    <= cfg_wdata_i;
        adcrf_pkg::CFG_DEFAULT_ENABLE: def_en_q  <= cfg_wdata_i[0];
        adcrf_pkg::CFG_DEFAULT_COUNT:  def_cnt_q <= cfg_wdata_i[adcrf_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      clr_word_q   <= '0;
    end else if (clr_active_q) begin
      clr_cnt_q  <= clr_cnt_q + AW'(1);
      clr_word_q <= (32'(clr_word_q) == KERNEL_WORDS - 1) ? '0 : clr_word_q + OW'(1);
      if (32'(clr_cnt_q) == DEPTH - 1) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // Result state updates for reads, continuous settings and posted results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NE; i++) begin
        conv_q[i]     <= '0;
        flag_q[i]     <= 1'b0;
        cont_q[i]     <= 1'b0;
        cont_cnt_q[i] <= '0;
        tag_q[i]      <= '0;
      end
    end else if (accept) begin
      if (mode == adcrf_pkg::MODE_READ && mapped && is_result && !cont_q[eidx]) begin
        flag_q[eidx] <= 1'b0;
      end
      if ((mode == adcrf_pkg::MODE_CONT || mode == adcrf_pkg::MODE_POST) && hit_entry) begin
        if (mode == adcrf_pkg::MODE_CONT) begin
          cont_q[eidx] <= count_present_i;
          if (count_present_i) begin
            cont_cnt_q[eidx] <= count_value_i;
          end
        end else begin
          conv_q[eidx] <= count_value_i;
          flag_q[eidx] <= 1'b1;
        end
        if (tag_present_i) begin
          tag_q[eidx] <= channel_tag_i;
        end
      end
    end
  end

  // Pipeline control and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_q        <= s1_d;
      out_valid_q <= s1_q.valid;
    end
  end

  // Output data register; the data is zero whenever no result is shown.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign result_valid_o = out_valid_q;
  assign read_data_o    = out_data_q;

endmodule

// ===== rtl/adcrf_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module adcrf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/adcrf_checker.sv =====
// Port-level checker of the ADC result register file, bound to the top level.
module adcrf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  mode_i,
  input logic        result_valid_o,
  input logic [31:0] read_data_o
);

  // Every taken command gives a result after the first stage and output registers.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 result_valid_o)
    else $error("taken command gave no result");

  // No result appears without a taken command behind it.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 2))
    else $error("result without a command");

  // Once the clearing pass is over, busy stays low.
  a_busy_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("busy rose after the clearing pass");

  // Commands other than bus reads return zero.
  a_zero_nonread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (mode_i != adcrf_pkg::MODE_READ) |-> ##2 read_data_o == '0)
    else $error("nonzero data for a command that is not a read");

  // Data is quiet between transfers.
  a_quiet_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o && $past(rst_ni) |-> read_data_o == '0)
    else $error("read data active without a transfer");

endmodule

bind adc_result_register_file adcrf_checker u_adcrf_checker (.*);
